### rtl/core/vrd_pkg.sv
// shared types, codes and escape-code classification for the dle deframer
package vrd_pkg;

	localparam logic [7:0] CODE_DLE = 8'h10;
	localparam logic [7:0] CODE_SUB = 8'h1A;
	localparam logic [7:0] CODE_ETX = 8'h03;

	localparam int VRD_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_EVENT   = 2'd1,
		KIND_END     = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLS_EVENT,
		CLS_INFO,
		CLS_UNKNOWN
	} esc_class_t;

	typedef enum logic [4:0] {
		EV_BONG        = 5'd0,
		EV_DTMF        = 5'd1,
		EV_BUSY        = 5'd2,
		EV_FAX_CALL    = 5'd3,
		EV_DIAL_TONE   = 5'd4,
		EV_DATA_CALL   = 5'd5,
		EV_ON_HOOK     = 5'd6,
		EV_OFF_HOOK    = 5'd7,
		EV_LOOP_BREAK  = 5'd8,
		EV_SIT_TONE    = 5'd9,
		EV_LOOP_POL    = 5'd10,
		EV_SILENCE     = 5'd11,
		EV_RINGBACK    = 5'd12,
		EV_RING        = 5'd13,
		EV_NO_VOICE    = 5'd14,
		EV_VOICE       = 5'd15,
		EV_CALL_WAIT   = 5'd16
	} event_t;

	typedef struct packed {
		esc_class_t cls;
		event_t     ev;
	} esc_info_t;

	// one queued request for the back end; dbl means emit two data DLEs
	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic [4:0] ev;
		logic       dbl;
	} cmd_t;

	function automatic esc_info_t classify(input logic [7:0] c);
		esc_info_t r;
		r.cls = CLS_EVENT;
		r.ev  = EV_BONG;
		if ((c >= "0" && c <= "9") || c == "*" || c == "#") begin
			r.ev = EV_DTMF;
		end else begin
			case (c)
				"$": r.ev = EV_BONG;
				"b": r.ev = EV_BUSY;
				"c": r.ev = EV_FAX_CALL;
				"d": r.ev = EV_DIAL_TONE;
				"e": r.ev = EV_DATA_CALL;
				"h": r.ev = EV_ON_HOOK;
				"t": r.ev = EV_OFF_HOOK;
				"I": r.ev = EV_LOOP_BREAK;
				"J": r.ev = EV_SIT_TONE;
				"L": r.ev = EV_LOOP_POL;
				"q": r.ev = EV_SILENCE;
				"r": r.ev = EV_RINGBACK;
				"R": r.ev = EV_RING;
				"s": r.ev = EV_NO_VOICE;
				"v", "V": r.ev = EV_VOICE;
				"w": r.ev = EV_CALL_WAIT;
				"/", "~", "E", "o", "Q", "S", "T", "u", "Y": r.cls = CLS_INFO;
				default: r.cls = CLS_UNKNOWN;
			endcase
		end
		return r;
	endfunction

endpackage

### rtl/core/vrd_front.sv
// front end: takes input requests, tracks escape state and builds back-end requests
module vrd_front import vrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       push,
	output cmd_t       push_cmd
);

	logic      after_escape_q;
	logic      finished_q;
	logic      esc_n;
	logic      fin_n;
	logic      produce;
	esc_info_t info;

	assign info = classify(rx_byte);

	always_comb begin
		esc_n            = after_escape_q;
		fin_n            = finished_q;
		produce          = 1'b0;
		push_cmd.kind    = KIND_DATA;
		push_cmd.payload = rx_byte;
		push_cmd.ev      = 5'd0;
		push_cmd.dbl     = 1'b0;
		if (action) begin
			esc_n = 1'b0;
			fin_n = 1'b0;
		end else if (!finished_q) begin
			if (!after_escape_q) begin
				if (rx_byte == CODE_DLE) begin
					esc_n = 1'b1;
				end else begin
					produce = 1'b1;
				end
			end else begin
				esc_n = 1'b0;
				if (rx_byte == CODE_DLE) begin
					produce = 1'b1;
				end else if (rx_byte == CODE_SUB) begin
					produce          = 1'b1;
					push_cmd.payload = CODE_DLE;
					push_cmd.dbl     = 1'b1;
				end else if (rx_byte == CODE_ETX) begin
					fin_n            = 1'b1;
					produce          = 1'b1;
					push_cmd.kind    = KIND_END;
					push_cmd.payload = 8'd0;
				end else if (info.cls == CLS_UNKNOWN) begin
					produce       = 1'b1;
					push_cmd.kind = KIND_UNKNOWN;
				end else if (info.cls == CLS_EVENT) begin
					produce       = 1'b1;
					push_cmd.kind = KIND_EVENT;
					push_cmd.ev   = info.ev;
					// only dtmf carries its character
					if (info.ev != EV_DTMF) begin
						push_cmd.payload = 8'd0;
					end
				end
			end
		end
	end

	assign push = accept && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_escape_q <= 1'b0;
			finished_q     <= 1'b0;
		end else if (accept) begin
			after_escape_q <= esc_n;
			finished_q     <= fin_n;
		end
	end

endmodule

### rtl/core/vrd_queue.sv
// small fifo of back-end requests between front and back end
module vrd_queue import vrd_pkg::*; #(
	parameter int Depth = VRD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cmd_t head
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

	cmd_t          mem_q [Depth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/core/vrd_back.sv
// back end: turns queued requests into results in the output register
module vrd_back import vrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  cmd_t       q_head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [4:0] event_code,
	output logic       last
);

	logic       valid_q;
	logic       second_q;
	logic       take;
	kind_t      kind_q;
	logic [7:0] payload_q;
	logic [4:0] event_q;
	logic       last_q;

	// output register is free when empty or being taken this cycle
	assign take = !valid_q || !out_stall;
	assign pop  = take && !second_q && q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (take) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else begin
				valid_q  <= q_not_empty;
				second_q <= q_not_empty && q_head.dbl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (second_q) begin
				kind_q    <= KIND_DATA;
				payload_q <= CODE_DLE;
				event_q   <= 5'd0;
				last_q    <= 1'b1;
			end else if (q_not_empty) begin
				kind_q    <= q_head.kind;
				payload_q <= q_head.payload;
				event_q   <= q_head.ev;
				last_q    <= !q_head.dbl;
			end
		end
	end

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign payload_byte = payload_q;
	assign event_code   = event_q;
	assign last         = last_q;

endmodule

### rtl/core/voice_rx_dle_deframer_top.sv
// top level of the voice receive dle deframer
// Removes DLE escaping from a received voice-modem byte stream. One input request is
// taken per cycle while in_stall is low; its results go from the front end into the
// request queue, then the output register. Every request gives at most one result,
// except DLE SUB, whose two data DLEs the back end emits one after the other; the
// queue of QueueDepth requests between front and back end absorbs these, and
// in_stall rises only when that queue is full. A start request clears the escape
// and end-of-recording flags and gives no result.
module voice_rx_dle_deframer_top import vrd_pkg::*; #(
	parameter int QueueDepth = VRD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [4:0] event_code,
	output logic       last
);

	logic accept;
	logic push;
	logic pop;
	logic full;
	logic q_not_empty;
	cmd_t push_cmd;
	cmd_t q_head;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	vrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.rx_byte  (rx_byte),
		.push     (push),
		.push_cmd (push_cmd)
	);

	vrd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	vrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.event_code   (event_code),
		.last         (last)
	);

endmodule

### rtl/core/vrd_checker.sv
// port-level checks for the dle deframer, bound to the top level
module vrd_checker import vrd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] payload_byte,
	input logic [4:0] event_code,
	input logic       last
);

	logic pend_q;

	// set between the first and second data DLE of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			pend_q <= !last;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte)
			&& $stable(event_code) && $stable(last))
		else $error("stalled result changed");

	a_nonlast_is_dle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> kind == KIND_DATA && payload_byte == CODE_DLE)
		else $error("non-last result is not a data DLE");

	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pend_q |-> kind == KIND_DATA && payload_byte == CODE_DLE && last)
		else $error("second DLE of a pair is wrong");

	a_event_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_EVENT |-> event_code == 5'd0)
		else $error("event code set on a non-event result");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> payload_byte == 8'd0 && last)
		else $error("end of recording result malformed");

endmodule

bind voice_rx_dle_deframer_top vrd_checker u_vrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.payload_byte (payload_byte),
	.event_code   (event_code),
	.last         (last)
);
